>>> hdl/lmcp_pkg.sv
// Shared types and constants for the LED matrix command parser.
// No dependencies; every other file in the block imports this package.
`default_nettype none

package lmcp_pkg;

  localparam int unsigned RowsDef    = 8;
  localparam int unsigned ColumnsDef = 16;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned ColW       = 4;
  localparam int unsigned RgbW       = 3;
  localparam int unsigned QDepth     = 2;

  localparam logic [ByteW-1:0] CmdReadback = 8'h5A;  // 'Z'
  localparam logic [ByteW-1:0] CmdColLo    = 8'h40;  // '@'
  localparam logic [ByteW-1:0] CmdColHi    = 8'h4F;  // 'O'
  localparam logic [ByteW-1:0] CmdClear    = 8'h00;

  typedef enum logic [1:0] {
    PH_CMD,
    PH_RED,
    PH_GREEN,
    PH_BLUE
  } phase_e;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_CLEAR,
    OP_READBACK
  } op_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_EMIT
  } back_state_e;

  typedef struct packed {
    op_e              op;
    logic [ColW-1:0]  column;
    logic [ByteW-1:0] red;
    logic [ByteW-1:0] green;
    logic [ByteW-1:0] blue;
  } cmd_t;

endpackage

`default_nettype wire

>>> hdl/led_matrix_command_parser.sv
// LED matrix command parser top level: parser, command queue and frame store unit.
// Depends on lmcp_pkg, lmcp_front, lmcp_queue and lmcp_back.
//
// Usage:
//   Slave side (s_axis_*) takes one received byte per request. Byte 0x40..0x4F selects a
//   column; the next three bytes are its red, green and blue bytes (bit 7 lands in row 0).
//   Byte 0x00 clears the frame store, 'Z' reads back the row-0 pixels; other commands drop.
//   Master side (m_axis_*) returns one request per pixel on a readback, columns 0 upward,
//   with tlast on the final pixel.
// Timing:
//   The parser takes one byte per cycle while the two-entry command queue has room.
//   Column writes and clears are done by the frame store unit as it pops them. A readback
//   handles each pixel as a registered memory read, then an output register load, and
//   pops the 'Z' command from the queue as it starts.
//   The first pixel passes through the queue, the memory read register and the output register.
// Reset:
//   Asynchronous, active low. Clears the parser phase, the queue and all column valid
//   bits at once, so every LED reads as off without a clearing pass.
// Stall:
//   When m_axis_tready is low the pixel holds in the output register and the readback
//   waits; bytes keep arriving until the queue fills, then s_axis_tready drops.
`default_nettype none

module led_matrix_command_parser #(
  parameter int unsigned Rows    = lmcp_pkg::RowsDef,
  parameter int unsigned Columns = lmcp_pkg::ColumnsDef
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire  [lmcp_pkg::ByteW-1:0]   s_axis_tdata,   // [7:0] in_byte
  output logic                         m_axis_tvalid,
  input  wire                          m_axis_tready,
  output logic [lmcp_pkg::ByteW-1:0]   m_axis_tdata,   // [2:0] pixel_rgb, [6:3] pixel_column
  output logic                         m_axis_tlast    // last_pixel
);
  import lmcp_pkg::*;

  // Parser to queue
  logic push;
  cmd_t push_cmd;
  logic full;

  // Queue to frame store unit
  logic pop;
  cmd_t head_cmd;
  logic empty;

  lmcp_front #(
    .Columns(Columns)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .push_o       (push),
    .cmd_o        (push_cmd),
    .full_i       (full)
  );

  // Hold commands here so parsing continues while a readback waits on the receiver
  lmcp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_cmd),
    .full_o (full),
    .pop_i  (pop),
    .data_o (head_cmd),
    .empty_o(empty)
  );

  lmcp_back #(
    .Rows   (Rows),
    .Columns(Columns)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (head_cmd),
    .empty_i      (empty),
    .pop_o        (pop),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule

`default_nettype wire

>>> hdl/lmcp_front.sv
// Byte parser: tracks the command phase and turns complete commands into queue entries.
// Depends on lmcp_pkg.
`default_nettype none

module lmcp_front #(
  parameter int unsigned Columns = lmcp_pkg::ColumnsDef
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire  [lmcp_pkg::ByteW-1:0]     s_axis_tdata,   // [7:0] in_byte
  output logic                           push_o,
  output lmcp_pkg::cmd_t                 cmd_o,
  input  wire                            full_i
);
  import lmcp_pkg::*;

  phase_e           phase_q, phase_d;
  logic [ColW-1:0]  target_q;
  logic [ByteW-1:0] red_q;
  logic [ByteW-1:0] green_q;
  logic             accept;
  logic             col_in_range;

  assign s_axis_tready = !full_i;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign col_in_range  = {1'b0, target_q} < (ColW + 1)'(Columns);

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      unique case (phase_q)
        PH_CMD: begin
          if (s_axis_tdata inside {[CmdColLo:CmdColHi]}) phase_d = PH_RED;
        end
        PH_RED:   phase_d = PH_GREEN;
        PH_GREEN: phase_d = PH_BLUE;
        PH_BLUE:  phase_d = PH_CMD;
        default:  phase_d = PH_CMD;
      endcase
    end
  end

  // Queue entry
  always_comb begin
    push_o        = 1'b0;
    cmd_o.op      = OP_WRITE;
    cmd_o.column  = target_q;
    cmd_o.red     = red_q;
    cmd_o.green   = green_q;
    cmd_o.blue    = s_axis_tdata;
    if (accept) begin
      unique case (phase_q)
        PH_CMD: begin
          if (s_axis_tdata == CmdReadback) begin
            push_o   = 1'b1;
            cmd_o.op = OP_READBACK;
          end else if (s_axis_tdata == CmdClear) begin
            push_o   = 1'b1;
            cmd_o.op = OP_CLEAR;
          end
        end
        PH_BLUE: push_o = col_in_range;
        default: push_o = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_CMD;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (phase_q == PH_CMD) target_q <= s_axis_tdata[ColW-1:0];
      if (phase_q == PH_RED) red_q <= s_axis_tdata;
      if (phase_q == PH_GREEN) green_q <= s_axis_tdata;
    end
  end

endmodule

`default_nettype wire

>>> hdl/lmcp_queue.sv
// Short command queue between the parser and the frame store unit.
// Depends on lmcp_pkg.
`default_nettype none

module lmcp_queue (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             push_i,
  input  lmcp_pkg::cmd_t  data_i,
  output logic            full_o,
  input  wire             pop_i,
  output lmcp_pkg::cmd_t  data_o,
  output logic            empty_o
);
  import lmcp_pkg::*;

  localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned CntW = $clog2(QDepth + 1);

  cmd_t            slots_q [QDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push;
  logic            do_pop;

  assign full_o  = count_q == CntW'(QDepth);
  assign empty_o = count_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) count_d = count_q + 1'b1;
    else if (do_pop && !do_push) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slots_q[wr_ptr_q] <= data_i;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push_i && full_o))
    else $error("queue push while full");

endmodule

`default_nettype wire

>>> hdl/lmcp_back.sv
// Frame store unit: column memory with per-column valid bits, clear and row-0 readback.
// Depends on lmcp_pkg.
`default_nettype none

module lmcp_back #(
  parameter int unsigned Rows    = lmcp_pkg::RowsDef,
  parameter int unsigned Columns = lmcp_pkg::ColumnsDef
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  lmcp_pkg::cmd_t               cmd_i,
  input  wire                          empty_i,
  output logic                         pop_o,
  output logic                         m_axis_tvalid,
  input  wire                          m_axis_tready,
  output logic [lmcp_pkg::ByteW-1:0]   m_axis_tdata,   // [2:0] pixel_rgb, [6:3] pixel_column
  output logic                         m_axis_tlast    // last_pixel
);
  import lmcp_pkg::*;

  localparam int unsigned AddrW  = (Columns > 1) ? $clog2(Columns) : 1;
  localparam int unsigned EntryW = Rows * RgbW;

  back_state_e         state_q, state_d;
  logic [AddrW-1:0]    col_q, col_d;
  logic [EntryW-1:0]   mem [Columns];
  logic [Columns-1:0]  valid_q;
  logic [EntryW-1:0]   rd_data_q;
  logic                rd_valid_q;
  logic [EntryW-1:0]   wr_data;
  logic                mem_we;
  logic                clr;
  logic                rd_en;
  logic                load;
  logic                out_free;
  logic                col_last;
  logic                out_valid_q;
  logic [RgbW-1:0]     out_rgb_q;
  logic [ColW-1:0]     out_col_q;
  logic                out_last_q;

  assign out_free = !out_valid_q || m_axis_tready;
  assign col_last = col_q == AddrW'(Columns - 1);

  // Row r of the column takes bit (7 - r) of each colour byte
  always_comb begin
    for (int r = 0; r < Rows; r++) begin
      wr_data[r*RgbW +: RgbW] = {cmd_i.red[ByteW-1-r], cmd_i.green[ByteW-1-r],
                                 cmd_i.blue[ByteW-1-r]};
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    col_d   = col_q;
    unique case (state_q)
      BK_IDLE: begin
        if (!empty_i && cmd_i.op == OP_READBACK) begin
          state_d = BK_READ;
          col_d   = '0;
        end
      end
      BK_READ: state_d = BK_EMIT;
      BK_EMIT: begin
        if (out_free) begin
          state_d = col_last ? BK_IDLE : BK_READ;
          col_d   = col_q + 1'b1;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    pop_o  = 1'b0;
    mem_we = 1'b0;
    clr    = 1'b0;
    rd_en  = 1'b0;
    load   = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        pop_o  = !empty_i;
        mem_we = !empty_i && cmd_i.op == OP_WRITE;
        clr    = !empty_i && cmd_i.op == OP_CLEAR;
      end
      BK_READ: rd_en = 1'b1;
      BK_EMIT: load  = out_free;
      default: pop_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      col_q       <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      if (clr) valid_q <= '0;
      else if (mem_we) valid_q[cmd_i.column[AddrW-1:0]] <= 1'b1;
      if (load) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[cmd_i.column[AddrW-1:0]] <= wr_data;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q  <= mem[col_q];
      rd_valid_q <= valid_q[col_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_rgb_q  <= rd_valid_q ? rd_data_q[RgbW-1:0] : '0;
      out_col_q  <= ColW'(col_q);
      out_last_q <= col_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(ByteW - RgbW - ColW){1'b0}}, out_col_q, out_rgb_q};
  assign m_axis_tlast  = out_last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_o |-> state_q == BK_IDLE)
    else $error("queue popped during readback");

  assert property (@(posedge clk_i) disable iff (!rst_ni) state_q == BK_READ |=> state_q == BK_EMIT)
    else $error("read not followed by emit");

  assert property (@(posedge clk_i) disable iff (!rst_ni) (load && col_last) |=> state_q == BK_IDLE)
    else $error("readback did not end after last column");

  assert property (@(posedge clk_i) disable iff (!rst_ni) clr |=> valid_q == '0)
    else $error("clear left valid columns");

endmodule

`default_nettype wire
